/* sv/lqi_pkg.sv */
// Package for the link quality indicator: beat structs, register codes, reset values,
// indicator modes, controller states and the quality-to-level mapping.
// Depends on nothing; every other file imports it.
`default_nettype none

package lqi_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 8;
  localparam int CFG_W          = 16;
  localparam int QUAL_W         = 7;
  localparam int LEVEL_W        = 8;
  localparam int MODE_W         = 2;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int DIV_STEPS      = QUAL_W;
  localparam int DIV_CNT_W      = 3;

  localparam logic [2:0] REG_SEND_INTERVAL = 3'd0;
  localparam logic [2:0] REG_STATS_WINDOW  = 3'd1;
  localparam logic [2:0] REG_LINK_LOST     = 3'd2;
  localparam logic [2:0] REG_BLINK_ON      = 3'd3;
  localparam logic [2:0] REG_BLINK_OFF     = 3'd4;

  localparam logic [CFG_W-1:0] SEND_INTERVAL_RST = 16'd150;
  localparam logic [CFG_W-1:0] STATS_WINDOW_RST  = 16'd900;
  localparam logic [CFG_W-1:0] LINK_LOST_RST     = 16'd2000;
  localparam logic [CFG_W-1:0] BLINK_ON_RST      = 16'd150;
  localparam logic [CFG_W-1:0] BLINK_OFF_RST     = 16'd1850;

  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINDING = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK = 8'd0;
  localparam logic [QUAL_W-1:0]  PCT_FULL   = 7'd100;

  typedef struct packed {
    logic button_click;
    logic ack_ok;
  } lqi_in_t;

  typedef struct packed {
    logic               send_now;
    logic               tx_bit;
    logic [LEVEL_W-1:0] led_level;
    logic [MODE_W-1:0]  led_mode;
    logic [QUAL_W-1:0]  quality_pct;
    logic               quality_valid;
  } lqi_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] send_period;
    logic [CFG_W-1:0] window_len;
    logic [CFG_W-1:0] lost_after;
    logic [CFG_W-1:0] blink_on_ms;
    logic [CFG_W-1:0] blink_off_ms;
  } lqi_cfg_t;

  typedef struct packed {
    logic step;
    logic div_start;
    logic div_step;
    logic apply;
    logic load_out;
  } lqi_cmd_t;

  typedef struct packed {
    logic win_due;
    logic div_last;
  } lqi_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_APPLY,
    ST_WRITE
  } lqi_state_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [QUAL_W-1:0] pct);
    logic [LEVEL_W-1:0] lvl;
    if (pct == 7'd0) begin
      lvl = 8'd0;
    end else if (pct >= 7'd90) begin
      lvl = 8'd255;
    end else if (pct >= 7'd70) begin
      lvl = 8'd204;
    end else if (pct >= 7'd50) begin
      lvl = 8'd153;
    end else if (pct >= 7'd30) begin
      lvl = 8'd102;
    end else begin
      lvl = 8'd51;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

/* sv/link_quality_indicator_top.sv */
// Top level of the link quality indicator: register file, controller and datapath.
// Depends on lqi_pkg, lqi_regs, lqi_ctrl and lqi_dp.
//
//   Channel  Signals                      Beat
//   in       in_valid, in_ready           lqi_in_t in_data, one millisecond tick
//   out      out_valid, out_ready         lqi_out_t out_data, one result per tick
//   config   psel, penable, pwrite, ...   16-bit register at byte address 4*index
//
// A tick without a window close passes from acceptance through the decide state to the
// write state, which loads its result; the next tick is accepted back in the idle state.
// A tick that closes a window passes through the decide, divide, apply and write states:
// the percentage comes from a shift-subtract divider that resolves one quotient bit per
// cycle, seven in all.
// The next tick is accepted while a result still waits in the output register; a waiting
// result holds the controller before its load until out_ready.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module link_quality_indicator_top #(
  parameter int TIMER_BITS = lqi_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = lqi_pkg::COUNT_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  lqi_pkg::lqi_in_t           in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output lqi_pkg::lqi_out_t          out_data,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [lqi_pkg::ADDR_W-1:0] paddr,
  input  wire  [lqi_pkg::DATA_W-1:0] pwdata,
  output logic [lqi_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lqi_pkg::*;

  lqi_cfg_t cfg;
  lqi_cmd_t cmd;
  lqi_sts_t sts;

  lqi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lqi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lqi_dp #(
    .TIMER_BITS (TIMER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* sv/lqi_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on lqi_pkg for the register codes, reset values and the config struct.
`default_nettype none

module lqi_regs (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [lqi_pkg::ADDR_W-1:0] paddr,
  input  wire  [lqi_pkg::DATA_W-1:0] pwdata,
  output logic [lqi_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lqi_pkg::lqi_cfg_t          cfg
);
  import lqi_pkg::*;

  logic [2:0]       reg_idx;
  logic             wr_en;
  logic [CFG_W-1:0] rd_val;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_period  <= SEND_INTERVAL_RST;
      cfg.window_len   <= STATS_WINDOW_RST;
      cfg.lost_after   <= LINK_LOST_RST;
      cfg.blink_on_ms  <= BLINK_ON_RST;
      cfg.blink_off_ms <= BLINK_OFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEND_INTERVAL: cfg.send_period  <= pwdata[CFG_W-1:0];
        REG_STATS_WINDOW:  cfg.window_len   <= pwdata[CFG_W-1:0];
        REG_LINK_LOST:     cfg.lost_after   <= pwdata[CFG_W-1:0];
        REG_BLINK_ON:      cfg.blink_on_ms  <= pwdata[CFG_W-1:0];
        REG_BLINK_OFF:     cfg.blink_off_ms <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEND_INTERVAL: rd_val = cfg.send_period;
      REG_STATS_WINDOW:  rd_val = cfg.window_len;
      REG_LINK_LOST:     rd_val = cfg.lost_after;
      REG_BLINK_ON:      rd_val = cfg.blink_on_ms;
      REG_BLINK_OFF:     rd_val = cfg.blink_off_ms;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-CFG_W){1'b0}}, rd_val};

endmodule

`default_nettype wire

/* sv/lqi_ctrl.sv */
// Controller state machine: sequences the tick update, the percentage divide,
// the window close and the output register. Depends on lqi_pkg.
`default_nettype none

module lqi_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  lqi_pkg::lqi_sts_t  sts,
  output lqi_pkg::lqi_cmd_t  cmd
);
  import lqi_pkg::*;

  lqi_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.win_due) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

/* sv/lqi_dp.sv */
// Datapath: elapsed timers, window counters, indicator state, the shift-subtract
// percentage divider and the output register. Depends on lqi_pkg.
`default_nettype none

module lqi_dp #(
  parameter int TIMER_BITS = lqi_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = lqi_pkg::COUNT_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  lqi_pkg::lqi_in_t   in_data,
  input  lqi_pkg::lqi_cfg_t  cfg,
  input  lqi_pkg::lqi_cmd_t  cmd,
  output lqi_pkg::lqi_sts_t  sts,
  output lqi_pkg::lqi_out_t  out_data
);
  import lqi_pkg::*;

  localparam int CMP_W = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
  localparam int NUM_W = COUNT_BITS + QUAL_W;

  logic [TIMER_BITS-1:0] since_send, since_send_next;
  logic [TIMER_BITS-1:0] since_window, since_window_next;
  logic [TIMER_BITS-1:0] since_ack, since_ack_next;
  logic [TIMER_BITS-1:0] blink_elapsed, blink_elapsed_next;
  logic                  ever_acked, ever_acked_next;
  logic [COUNT_BITS-1:0] attempt_count, attempt_count_next;
  logic [COUNT_BITS-1:0] success_count, success_count_next;
  logic [QUAL_W-1:0]     last_quality, last_quality_next;
  logic [MODE_W-1:0]     indicator_mode, indicator_mode_next;
  logic [LEVEL_W-1:0]    on_level, on_level_next;
  logic [LEVEL_W-1:0]    level_out, level_out_next;
  logic                  toggle_bit, toggle_bit_next;
  logic                  send_flag, send_flag_next;
  logic                  win_flag, win_flag_next;

  logic [NUM_W-1:0]      rem, rem_next;
  logic [NUM_W-1:0]      dsh, dsh_next;
  logic [QUAL_W-1:0]     quot, quot_next;
  logic [DIV_CNT_W-1:0]  div_cnt, div_cnt_next;

  logic [TIMER_BITS-1:0] ss_inc, sw_inc, sa_inc, be_inc;
  logic [COUNT_BITS-1:0] att_inc, suc_inc;
  logic [CMP_W-1:0]      ss_ext, sw_now_ext, sa_ext, sa_now_ext, be_ext;
  logic [CMP_W-1:0]      interval_ext, window_ext, lost_ext, on_ext, period_ext;
  logic                  send_due, ack_taken, lost_step, lost_now;
  logic [NUM_W-1:0]      numer;
  logic                  div_fit;
  logic [QUAL_W-1:0]     pct;
  logic [LEVEL_W-1:0]    pwm;

  assign ss_inc  = (since_send == '1)    ? since_send    : since_send + 1'b1;
  assign sw_inc  = (since_window == '1)  ? since_window  : since_window + 1'b1;
  assign sa_inc  = (since_ack == '1)     ? since_ack     : since_ack + 1'b1;
  assign be_inc  = (blink_elapsed == '1) ? blink_elapsed : blink_elapsed + 1'b1;
  assign att_inc = (attempt_count == '1) ? attempt_count : attempt_count + 1'b1;
  assign suc_inc = (success_count == '1) ? success_count : success_count + 1'b1;

  assign ss_ext     = {{(CMP_W-TIMER_BITS){1'b0}}, ss_inc};
  assign sw_now_ext = {{(CMP_W-TIMER_BITS){1'b0}}, since_window};
  assign sa_ext     = {{(CMP_W-TIMER_BITS){1'b0}}, sa_inc};
  assign sa_now_ext = {{(CMP_W-TIMER_BITS){1'b0}}, since_ack};
  assign be_ext     = {{(CMP_W-TIMER_BITS){1'b0}}, be_inc};

  assign interval_ext = {{(CMP_W-CFG_W){1'b0}}, cfg.send_period};
  assign window_ext   = {{(CMP_W-CFG_W){1'b0}}, cfg.window_len};
  assign lost_ext     = {{(CMP_W-CFG_W){1'b0}}, cfg.lost_after};
  assign on_ext       = {{(CMP_W-CFG_W){1'b0}}, cfg.blink_on_ms};
  assign period_ext   = on_ext + {{(CMP_W-CFG_W){1'b0}}, cfg.blink_off_ms};

  assign send_due  = ss_ext >= interval_ext;
  assign ack_taken = send_due & in_data.ack_ok;
  assign lost_step = ack_taken ? 1'b0 : (!ever_acked || (sa_ext > lost_ext));
  assign lost_now  = !ever_acked || (sa_now_ext > lost_ext);

  assign numer   = NUM_W'(success_count) * NUM_W'(PCT_FULL);
  assign div_fit = rem >= dsh;
  assign pct     = (attempt_count == '0) ? '0 : ((quot > PCT_FULL) ? PCT_FULL : quot);
  assign pwm     = level_of(pct);

  assign sts.win_due  = sw_now_ext >= window_ext;
  assign sts.div_last = (div_cnt == '0);

  always_comb begin
    since_send_next     = since_send;
    since_window_next   = since_window;
    since_ack_next      = since_ack;
    blink_elapsed_next  = blink_elapsed;
    ever_acked_next     = ever_acked;
    attempt_count_next  = attempt_count;
    success_count_next  = success_count;
    last_quality_next   = last_quality;
    indicator_mode_next = indicator_mode;
    on_level_next       = on_level;
    level_out_next      = level_out;
    toggle_bit_next     = toggle_bit;
    send_flag_next      = send_flag;
    win_flag_next       = win_flag;

    if (cmd.step) begin
      since_send_next    = ss_inc;
      since_window_next  = sw_inc;
      since_ack_next     = sa_inc;
      blink_elapsed_next = be_inc;
      win_flag_next      = 1'b0;
      send_flag_next     = send_due;
      toggle_bit_next    = toggle_bit ^ in_data.button_click;

      if (indicator_mode == MODE_ON) begin
        level_out_next = on_level;
      end else if (indicator_mode == MODE_FINDING) begin
        if (be_ext < on_ext) begin
          level_out_next = LEVEL_FULL;
        end else if (be_ext < period_ext) begin
          level_out_next = LEVEL_DARK;
        end else begin
          blink_elapsed_next = '0;
        end
      end

      if (send_due) begin
        since_send_next    = '0;
        attempt_count_next = att_inc;
        if (in_data.ack_ok) begin
          success_count_next = suc_inc;
          since_ack_next     = '0;
          ever_acked_next    = 1'b1;
          if (indicator_mode == MODE_FINDING) begin
            level_out_next      = LEVEL_FULL;
            on_level_next       = LEVEL_FULL;
            indicator_mode_next = MODE_ON;
          end
        end
      end

      if (lost_step && (indicator_mode_next != MODE_FINDING)) begin
        indicator_mode_next = MODE_FINDING;
        blink_elapsed_next  = '0;
        level_out_next      = LEVEL_DARK;
      end
    end

    if (cmd.apply) begin
      last_quality_next  = pct;
      win_flag_next      = 1'b1;
      attempt_count_next = '0;
      success_count_next = '0;
      since_window_next  = '0;
      if (!lost_now && (pwm != LEVEL_DARK)) begin
        indicator_mode_next = MODE_ON;
        on_level_next       = pwm;
        level_out_next      = pwm;
      end else if (indicator_mode != MODE_FINDING) begin
        indicator_mode_next = MODE_FINDING;
        blink_elapsed_next  = '0;
        level_out_next      = LEVEL_DARK;
      end
    end
  end

  always_comb begin
    rem_next     = rem;
    dsh_next     = dsh;
    quot_next    = quot;
    div_cnt_next = div_cnt;
    if (cmd.div_start) begin
      rem_next     = numer;
      dsh_next     = {1'b0, attempt_count, {(QUAL_W-1){1'b0}}};
      quot_next    = '0;
      div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem_next     = div_fit ? rem - dsh : rem;
      dsh_next     = dsh >> 1;
      quot_next    = {quot[QUAL_W-2:0], div_fit};
      div_cnt_next = div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_send     <= '0;
      since_window   <= '0;
      since_ack      <= '0;
      blink_elapsed  <= '0;
      ever_acked     <= 1'b0;
      attempt_count  <= '0;
      success_count  <= '0;
      last_quality   <= '0;
      indicator_mode <= MODE_FINDING;
      on_level       <= '0;
      level_out      <= '0;
      toggle_bit     <= 1'b0;
      send_flag      <= 1'b0;
      win_flag       <= 1'b0;
      div_cnt        <= '0;
    end else begin
      since_send     <= since_send_next;
      since_window   <= since_window_next;
      since_ack      <= since_ack_next;
      blink_elapsed  <= blink_elapsed_next;
      ever_acked     <= ever_acked_next;
      attempt_count  <= attempt_count_next;
      success_count  <= success_count_next;
      last_quality   <= last_quality_next;
      indicator_mode <= indicator_mode_next;
      on_level       <= on_level_next;
      level_out      <= level_out_next;
      toggle_bit     <= toggle_bit_next;
      send_flag      <= send_flag_next;
      win_flag       <= win_flag_next;
      div_cnt        <= div_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    dsh  <= dsh_next;
    quot <= quot_next;
    if (cmd.load_out) begin
      out_data.send_now      <= send_flag;
      out_data.tx_bit        <= toggle_bit;
      out_data.led_level     <= level_out;
      out_data.led_mode      <= indicator_mode;
      out_data.quality_pct   <= last_quality;
      out_data.quality_valid <= win_flag;
    end
  end

endmodule

`default_nettype wire

/* dv/link_quality_indicator_top_tb.sv */
// Self-checking testbench for link_quality_indicator_top: ticks go in over a valid/ready
// channel, each result beat is checked against a tick-by-tick predictor of the indicator.
// Depends on lqi_pkg and the RTL under sv/.
`timescale 1ns / 100ps

module link_quality_indicator_top_tb;
  import lqi_pkg::*;

  class lqi_indicator_tracker;
    int interval_ms, window_ms, lost_ms, lit_ms, dark_ms;
    logic [15:0] since_send, since_window, since_ack, blink_age;
    bit ever_acked, toggle;
    logic [7:0] attempts, acked;
    logic [6:0] quality;
    logic [MODE_W-1:0] mode;
    logic [7:0] lit_level, level;
    lqi_out_t reports_due[$];
    int errors;

    function new();
      interval_ms = SEND_INTERVAL_RST;
      window_ms = STATS_WINDOW_RST;
      lost_ms = LINK_LOST_RST;
      lit_ms = BLINK_ON_RST;
      dark_ms = BLINK_OFF_RST;
      since_send = '0;
      since_window = '0;
      since_ack = '0;
      blink_age = '0;
      ever_acked = 1'b0;
      toggle = 1'b0;
      attempts = '0;
      acked = '0;
      quality = '0;
      mode = MODE_FINDING;
      lit_level = '0;
      level = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_SEND_INTERVAL: interval_ms = val;
        REG_STATS_WINDOW: window_ms = val;
        REG_LINK_LOST: lost_ms = val;
        REG_BLINK_ON: lit_ms = val;
        REG_BLINK_OFF: dark_ms = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] age(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function logic [7:0] tally(logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function bit link_down();
      return !ever_acked || int'(since_ack) > lost_ms;
    endfunction

    function void start_search();
      if (mode != MODE_FINDING) begin
        mode = MODE_FINDING;
        blink_age = '0;
        level = LEVEL_DARK;
      end
    endfunction

    function logic [7:0] pwm_for(int pct);
      int step_pct;
      if (pct == 0) step_pct = 0;
      else if (pct >= 90) step_pct = 100;
      else if (pct >= 70) step_pct = 80;
      else if (pct >= 50) step_pct = 60;
      else if (pct >= 30) step_pct = 40;
      else step_pct = 20;
      return 8'((step_pct * 255) / 100);
    endfunction

    function void note_tick(lqi_in_t beat);
      lqi_out_t r;
      int pct;
      logic [7:0] pwm;
      r = '0;
      since_send = age(since_send);
      since_window = age(since_window);
      since_ack = age(since_ack);
      blink_age = age(blink_age);

      if (mode == MODE_ON) begin
        level = lit_level;
      end else if (mode == MODE_FINDING) begin
        if (int'(blink_age) < lit_ms) level = LEVEL_FULL;
        else if (int'(blink_age) < lit_ms + dark_ms) level = LEVEL_DARK;
        else blink_age = '0;
      end

      if (beat.button_click) toggle = !toggle;

      if (int'(since_send) >= interval_ms) begin
        since_send = '0;
        r.send_now = 1'b1;
        attempts = tally(attempts);
        if (beat.ack_ok) begin
          acked = tally(acked);
          since_ack = '0;
          ever_acked = 1'b1;
          if (mode == MODE_FINDING) begin
            level = LEVEL_FULL;
            lit_level = LEVEL_FULL;
            mode = MODE_ON;
          end
        end
      end

      if (link_down()) start_search();

      if (int'(since_window) >= window_ms) begin
        pct = (attempts != 0) ? (int'(acked) * 100) / int'(attempts) : 0;
        if (pct > 100) pct = 100;
        quality = 7'(pct);
        r.quality_valid = 1'b1;
        attempts = '0;
        acked = '0;
        since_window = '0;
        if (!link_down()) begin
          pwm = pwm_for(pct);
          if (pwm == 0) begin
            start_search();
          end else begin
            mode = MODE_ON;
            lit_level = pwm;
            level = pwm;
          end
        end else begin
          start_search();
        end
      end

      r.tx_bit = toggle;
      r.led_level = level;
      r.led_mode = mode;
      r.quality_pct = quality;
      reports_due.push_back(r);
    endfunction

    function void compare_field(string name, int want, logic [7:0] got);
      if (got !== 8'(want)) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_report(lqi_out_t got);
      lqi_out_t want;
      if (reports_due.size() == 0) begin
        errors++;
        $error("result beat arrived with no tick outstanding");
        return;
      end
      want = reports_due.pop_front();
      compare_field("send_now", want.send_now, got.send_now);
      compare_field("tx_bit", want.tx_bit, got.tx_bit);
      compare_field("led_level", want.led_level, got.led_level);
      compare_field("led_mode", want.led_mode, got.led_mode);
      compare_field("quality_pct", want.quality_pct, got.quality_pct);
      compare_field("quality_valid", want.quality_valid, got.quality_valid);
    endfunction

    function int outstanding();
      return reports_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lqi_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lqi_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int gap_pct = 0;
  int stall_pct = 0;
  lqi_indicator_tracker tracker = new();

  link_quality_indicator_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_tick(in_data);
    if (!rst && out_valid && out_ready) tracker.check_report(out_data);
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_timing(int interval, int window, int lost, int lit, int dark);
    write_reg(REG_SEND_INTERVAL, 16'(interval));
    write_reg(REG_STATS_WINDOW, 16'(window));
    write_reg(REG_LINK_LOST, 16'(lost));
    write_reg(REG_BLINK_ON, 16'(lit));
    write_reg(REG_BLINK_OFF, 16'(dark));
  endtask

  task automatic drive_tick(bit click, bit ack);
    lqi_in_t beat;
    beat.button_click = click;
    beat.ack_ok = ack;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(int interval, int window, int lost, int lit, int dark,
                           int ticks, int gap, int stall);
    int ack_odds;
    int odds_list[7] = '{0, 15, 35, 55, 75, 92, 100};
    gap_pct = gap;
    stall_pct = stall;
    set_timing(interval, window, lost, lit, dark);
    ack_odds = odds_list[$urandom_range(0, 6)];
    for (int i = 0; i < ticks; i++) begin
      if (i % 40 == 39) ack_odds = odds_list[$urandom_range(0, 6)];
      if (i == ticks / 2) wait_drained();
      drive_tick($urandom_range(0, 99) < 30, $urandom_range(0, 99) < ack_odds);
    end
    wait_drained();
  endtask

  task automatic run_directed();
    bit ack_seq[25] = '{1, 1, 1, 1, 1,  1, 1, 1, 1, 0,  1, 1, 1, 0, 0,
                        0, 0, 0, 1, 1,  0, 0, 0, 0, 1};
    gap_pct = 0;
    stall_pct = 0;
    set_timing(1, 5, 2, 2, 3);
    for (int i = 0; i < 25; i++) begin
      drive_tick(i % 3 == 0, ack_seq[i]);
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_phase(1, 300, 10, 3, 4, 350, 0, 0);
    run_phase(2, 20, 5, 2, 5, 300, 45, 0);
    run_phase(3, 10, 65535, 65535, 65535, 250, 0, 45);
    run_phase(65535, 7, 1, 1, 65535, 150, 21, 21);
    run_phase(1, 1, 1, 5, 1, 250, 21, 21);
    run_phase(5, 65535, 40, 4, 6, 200, 0, 0);
    run_phase(150, 900, 2000, 150, 1850, 200, 0, 45);
    repeat (30) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("link_quality_indicator_top: match");
    end else begin
      $display("link_quality_indicator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("link_quality_indicator_top: mismatch");
    $finish;
  end

endmodule
